// ===== rtl/sfst_pkg.sv =====
// ----------------------------------------------------------------------------
// Smallest-factor sieve package
// Widths, codes, sequencer states and divider request/response types shared
// by the sieve table block.
// ----------------------------------------------------------------------------
package sfst_pkg;

    localparam int LIMIT_W    = 17;
    localparam int INDEX_W    = 16;
    localparam int FACTOR_W   = 8;
    localparam int OUTER_W    = 9;
    localparam int SQ_W       = 18;
    localparam int X_W        = 16;
    localparam int DIV_CNT_W  = $clog2(LIMIT_W);

    localparam int unsigned TABLE_SIZE_DEF = 65536;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(65536);

    localparam logic OP_BUILD  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_OUTER_TEST,
        S_OUTER_CHK,
        S_DIV_WAIT,
        S_INNER_TEST,
        S_INNER_CHK,
        S_LK_DATA,
        S_EMIT
    } sfst_state_t;

    typedef struct packed {
        logic               start;
        logic [LIMIT_W-1:0] dividend;
        logic [OUTER_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [LIMIT_W-1:0] quotient;
        logic [OUTER_W-1:0] remainder;
    } div_rsp_t;

endpackage

// ===== rtl/sfst_ifs.sv =====
// ----------------------------------------------------------------------------
// Sieve table channels
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface sfst_in_if import sfst_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               op;
    logic [INDEX_W-1:0] index;

    modport source (output valid, op, index, input ready);
    modport sink (input valid, op, index, output ready);
endinterface

interface sfst_out_if import sfst_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FACTOR_W-1:0] factor;
    logic                is_prime;
    logic                valid_res;

    modport source (output valid, factor, is_prime, valid_res, input ready);
    modport sink (input valid, factor, is_prime, valid_res, output ready);
endinterface

// ===== rtl/smallest_factor_sieve_table_top.sv =====
// A lookup beat with an index in range is read from the table, then passes S_LK_DATA
// and S_EMIT before its result beat is registered; any other lookup goes straight
// to S_EMIT. A build beat clears the n entries in use, then runs the divider and an
// inner walk for each prime p with p * p < n; its length is set by the single table
// port walked one entry per step. One command is in work at a time; the input is
// ready only when idle. Reset clears control state only.
// ----------------------------------------------------------------------------
// Smallest-factor sieve table
// Sequencer that clears and sieves a table of smallest prime factors through
// one memory port, then answers single-index lookups.
// ----------------------------------------------------------------------------
module smallest_factor_sieve_table_top import sfst_pkg::*;
#(
    parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    sfst_in_if.sink            cmd,
    sfst_out_if.source         res,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata
);

    localparam int ADDR_W   = $clog2(TABLE_SIZE);
    localparam int ENTRY_W0 = (ADDR_W + 1) / 2;
    localparam int ENTRY_W  = (ENTRY_W0 > OUTER_W) ? OUTER_W : ENTRY_W0;
    localparam bit SIZE_CAPS = (TABLE_SIZE < (2 ** LIMIT_W));
    localparam logic [LIMIT_W-1:0] SIZE_CAP = SIZE_CAPS ? LIMIT_W'(TABLE_SIZE) : '1;

    sfst_state_t         state_reg, state_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;
    logic                built_reg, built_next;
    logic [OUTER_W-1:0]  i_reg, i_next;
    logic [SQ_W-1:0]     sq_reg, sq_next;
    logic [X_W-1:0]      x_reg, x_next;
    logic [LIMIT_W-1:0]  m_reg, m_next;
    logic [FACTOR_W-1:0] pend_factor_reg, pend_factor_next;
    logic                pend_prime_reg, pend_prime_next;
    logic                pend_vres_reg, pend_vres_next;
    logic                res_valid_reg, res_valid_next;
    logic [FACTOR_W-1:0] res_factor_reg, res_factor_next;
    logic                res_prime_reg, res_prime_next;
    logic                res_vres_reg, res_vres_next;
    logic [ENTRY_W-1:0]  rd_data_reg;

    logic [ENTRY_W-1:0]  mem [TABLE_SIZE];
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;

    logic [LIMIT_W-1:0]  n_used;
    logic [SQ_W-1:0]     sq_step;
    logic                lookup_ok;
    logic                emit_free;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    sfst_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= LIMIT_RESET;
            built_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            built_reg     <= built_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg           <= i_next;
        sq_reg          <= sq_next;
        x_reg           <= x_next;
        m_reg           <= m_next;
        pend_factor_reg <= pend_factor_next;
        pend_prime_reg  <= pend_prime_next;
        pend_vres_reg   <= pend_vres_next;
        res_factor_reg  <= res_factor_next;
        res_prime_reg   <= res_prime_next;
        res_vres_reg    <= res_vres_next;
    end

    assign n_used    = (SIZE_CAPS && (limit_reg > SIZE_CAP)) ? SIZE_CAP : limit_reg;
    assign sq_step   = sq_reg + SQ_W'({i_reg, 1'b0}) + SQ_W'(1);
    assign lookup_ok = built_reg && (cmd.index >= INDEX_W'(2))
                       && (LIMIT_W'(cmd.index) < n_used);
    assign emit_free = !res_valid_reg || res.ready;

    always_comb
    begin
        state_next       = state_reg;
        limit_next       = limit_reg;
        built_next       = built_reg;
        i_next           = i_reg;
        sq_next          = sq_reg;
        x_next           = x_reg;
        m_next           = m_reg;
        pend_factor_next = pend_factor_reg;
        pend_prime_next  = pend_prime_reg;
        pend_vres_next   = pend_vres_reg;
        res_valid_next   = res_valid_reg && !res.ready;
        res_factor_next  = res_factor_reg;
        res_prime_next   = res_prime_reg;
        res_vres_next    = res_vres_reg;
        mem_we           = 1'b0;
        mem_waddr        = ADDR_W'(m_reg);
        mem_wdata        = '0;
        mem_re           = 1'b0;
        mem_raddr        = ADDR_W'(x_reg);
        div_req.start    = 1'b0;
        div_req.dividend = n_used;
        div_req.divisor  = i_reg;
        cmd.ready        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    if (cmd.op == OP_BUILD)
                    begin
                        m_next     = '0;
                        state_next = S_CLEAR;
                    end
                    else if (lookup_ok)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = ADDR_W'(cmd.index);
                        state_next = S_LK_DATA;
                    end
                    else
                    begin
                        pend_factor_next = '0;
                        pend_prime_next  = 1'b0;
                        pend_vres_next   = 1'b0;
                        state_next       = S_EMIT;
                    end
                end
            end
            S_CLEAR:
            begin
                if (m_reg < n_used)
                begin
                    mem_we = 1'b1;
                    m_next = m_reg + LIMIT_W'(1);
                end
                else
                begin
                    i_next     = OUTER_W'(2);
                    sq_next    = SQ_W'(4);
                    state_next = S_OUTER_TEST;
                end
            end
            S_OUTER_TEST:
            begin
                if (sq_reg < SQ_W'(n_used))
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ADDR_W'(i_reg);
                    state_next = S_OUTER_CHK;
                end
                else
                begin
                    built_next       = 1'b1;
                    pend_factor_next = '0;
                    pend_prime_next  = 1'b0;
                    pend_vres_next   = 1'b1;
                    state_next       = S_EMIT;
                end
            end
            S_OUTER_CHK:
            begin
                if (rd_data_reg != '0)
                begin
                    i_next     = i_reg + OUTER_W'(1);
                    sq_next    = sq_step;
                    state_next = S_OUTER_TEST;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    x_next     = X_W'(div_rsp.quotient);
                    m_next     = n_used - LIMIT_W'(div_rsp.remainder);
                    state_next = S_INNER_TEST;
                end
            end
            S_INNER_TEST:
            begin
                if (x_reg >= X_W'(i_reg))
                begin
                    mem_re     = 1'b1;
                    state_next = S_INNER_CHK;
                end
                else
                begin
                    i_next     = i_reg + OUTER_W'(1);
                    sq_next    = sq_step;
                    state_next = S_OUTER_TEST;
                end
            end
            S_INNER_CHK:
            begin
                if ((rd_data_reg == '0) && (m_reg < n_used))
                begin
                    mem_we    = 1'b1;
                    mem_wdata = ENTRY_W'(i_reg);
                end
                x_next     = x_reg - X_W'(1);
                m_next     = m_reg - LIMIT_W'(i_reg);
                state_next = S_INNER_TEST;
            end
            S_LK_DATA:
            begin
                pend_factor_next = FACTOR_W'(rd_data_reg);
                pend_prime_next  = (rd_data_reg == '0);
                pend_vres_next   = 1'b1;
                state_next       = S_EMIT;
            end
            S_EMIT:
            begin
                if (emit_free)
                begin
                    res_valid_next  = 1'b1;
                    res_factor_next = pend_factor_reg;
                    res_prime_next  = pend_prime_reg;
                    res_vres_next   = pend_vres_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            limit_next = cfg_wdata;
            built_next = 1'b0;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.factor    = res_factor_reg;
    assign res.is_prime  = res_prime_reg;
    assign res.valid_res = res_vres_reg;

    a_write_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_INNER_CHK))
        else $error("table written outside a build");

    a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INNER_CHK) |-> (m_reg <= n_used))
        else $error("mark address beyond the entries in use");

    a_prime_no_factor: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_prime_reg) |-> (res_factor_reg == '0 && res_vres_reg))
        else $error("prime result carries a factor");

    a_cfg_unbuilds: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !built_reg)
        else $error("table still marked built after a limit write");

    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV_WAIT))
        else $error("divider finished outside its wait state");

endmodule

// ===== rtl/sfst_div.sv =====
// ----------------------------------------------------------------------------
// Sieve table divider
// Restoring divider giving one quotient bit per cycle; yields the start point
// of each inner walk and its remainder.
// ----------------------------------------------------------------------------
module sfst_div import sfst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [LIMIT_W-1:0]   quo_reg, quo_next;
    logic [OUTER_W-1:0]   rem_reg, rem_next;
    logic [OUTER_W-1:0]   dvs_reg, dvs_next;
    logic [OUTER_W:0]     shifted;
    logic [OUTER_W+1:0]   trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg, quo_reg[LIMIT_W-1]};
        trial     = {1'b0, shifted} - {2'b00, dvs_reg};

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(LIMIT_W - 1);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[OUTER_W+1])
            begin
                rem_next = trial[OUTER_W-1:0];
                quo_next = {quo_reg[LIMIT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[OUTER_W-1:0];
                quo_next = {quo_reg[LIMIT_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - DIV_CNT_W'(1);
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule
